@@ src/sgm_pkg.sv @@
// Shared types and constants for the Sobel gradient magnitude block.
`default_nettype none

package sgm_pkg;

    localparam int PIX_W      = 8;
    localparam int WIDTH_CFG_W  = 12;
    localparam int HEIGHT_CFG_W = 13;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 1;
    localparam int MIN_DIM    = 3;
    localparam int WIN_TAPS   = 6;
    localparam int GRAD_W     = 11;
    localparam int QUOT_W     = 9;
    localparam int SQ_W       = 16;
    localparam int SUM_W      = 17;
    localparam int BIT_IDX_W  = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'b1;

    typedef logic [PIX_W-1:0]         t_pixel;
    typedef logic signed [GRAD_W-1:0] t_grad;

    // commands from the controller to the datapath
    typedef struct packed {
        logic                 accept;
        logic                 window;
        logic                 square;
        logic                 sum;
        logic                 root_step;
        logic [BIT_IDX_W-1:0] root_bit;
        logic                 load_out;
    } t_dp_cmd;

    // status from the datapath to the controller
    typedef struct packed {
        logic result_due;
        logic out_free;
    } t_dp_status;

endpackage

`default_nettype wire

@@ src/sobel_gradient_magnitude.sv @@
// Top level of the Sobel gradient magnitude block over a raster pixel stream.
//
//  channel   direction  handshake          payload
//  pixel     in         i_valid / o_stall  i_gray_pixel
//  result    out        o_valid / i_stall  o_edge_magnitude, o_frame_last
//  config    in         i_cfg_we           i_cfg_index, i_cfg_data
//
// A pixel that yields no result (first two rows, first two columns) goes through
// transfer with line store read, then window update and write back.
// An interior pixel adds square, sum, root and output load steps; the square root
// resolves one bit per cycle through a single 8x8 multiplier.
// The result sits in an output register; the next pixel is taken while it waits,
// and a stalled result holds the controller only once the next one is ready.
// Reset is synchronous, active low; a configuration write restarts the frame.
`default_nettype none

module sobel_gradient_magnitude
    import sgm_pkg::*;
#(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 4096
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_cfg_we,
    input  wire [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire [CFG_DATA_W-1:0] i_cfg_data,
    input  wire                  i_valid,
    output logic                 o_stall,
    input  wire [PIX_W-1:0]      i_gray_pixel,
    output logic                 o_valid,
    input  wire                  i_stall,
    output logic [PIX_W-1:0]     o_edge_magnitude,
    output logic                 o_frame_last
);

    t_dp_cmd    cmd;
    t_dp_status status;

    sgm_control u_control (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_status (status),
        .o_cmd    (cmd)
    );

    sgm_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_gray_pixel     (i_gray_pixel),
        .i_stall          (i_stall),
        .i_cmd            (cmd),
        .o_status         (status),
        .o_valid          (o_valid),
        .o_edge_magnitude (o_edge_magnitude),
        .o_frame_last     (o_frame_last)
    );

endmodule

`default_nettype wire

@@ src/sgm_datapath.sv @@
// Datapath: line stores, 3x3 window, Sobel sums, squares, root and output register.
`default_nettype none

module sgm_datapath
    import sgm_pkg::*;
#(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 4096
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_cfg_we,
    input  wire [CFG_IDX_W-1:0]   i_cfg_index,
    input  wire [CFG_DATA_W-1:0]  i_cfg_data,
    input  wire t_pixel           i_gray_pixel,
    input  wire                   i_stall,
    input  wire t_dp_cmd          i_cmd,
    output t_dp_status            o_status,
    output logic                  o_valid,
    output t_pixel                o_edge_magnitude,
    output logic                  o_frame_last
);

    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int HW = $clog2(MAX_HEIGHT + 1);

    logic [WIDTH_CFG_W-1:0]  r_width_cfg;
    logic [HEIGHT_CFG_W-1:0] r_height_cfg;
    logic [CW-1:0]           r_col;
    logic [RW-1:0]           r_row;
    t_pixel                  r_win [WIN_TAPS];
    t_pixel                  r_pixel;
    t_pixel                  r_rd_top;
    t_pixel                  r_rd_mid;
    t_grad                   r_gx;
    t_grad                   r_gy;
    logic                    r_last;
    logic [SQ_W-1:0]         r_sq_x;
    logic [SQ_W-1:0]         r_sq_y;
    logic [SUM_W-1:0]        r_sum;
    t_pixel                  r_root;
    t_pixel                  r_out_mag;
    logic                    r_out_last;
    logic                    r_out_valid;

    t_pixel line_store_above     [MAX_WIDTH];
    t_pixel line_store_two_above [MAX_WIDTH];

    logic [WW-1:0]           w_eff;
    logic [HW-1:0]           h_eff;
    logic [WW:0]             col_inc;
    logic [HW:0]             row_inc;
    logic [CW-1:0]           n_col;
    logic [RW-1:0]           n_row;
    logic                    row_wrap;
    t_grad                   n_gx;
    t_grad                   n_gy;
    t_grad                   lt, lm, lb, ct, cb, rt, rm, rb;
    logic signed [QUOT_W-1:0] qx;
    logic signed [QUOT_W-1:0] qy;
    logic signed [2*QUOT_W-1:0] px2;
    logic signed [2*QUOT_W-1:0] py2;
    t_pixel                  trial;
    logic [2*PIX_W-1:0]      trial_sq;
    logic                    out_free;

    // clamp the frame size to the legal range
    always_comb begin
        if (r_width_cfg < WIDTH_CFG_W'(MIN_DIM)) begin
            w_eff = WW'(MIN_DIM);
        end else if (32'(r_width_cfg) > 32'(MAX_WIDTH)) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(r_width_cfg);
        end
        if (r_height_cfg < HEIGHT_CFG_W'(MIN_DIM)) begin
            h_eff = HW'(MIN_DIM);
        end else if (32'(r_height_cfg) > 32'(MAX_HEIGHT)) begin
            h_eff = HW'(MAX_HEIGHT);
        end else begin
            h_eff = HW'(r_height_cfg);
        end
    end

    assign col_inc  = (WW+1)'(r_col) + (WW+1)'(1);
    assign row_inc  = (HW+1)'(r_row) + (HW+1)'(1);
    assign row_wrap = col_inc >= {1'b0, w_eff};
    assign n_col    = row_wrap ? '0 : CW'(col_inc);
    assign n_row    = !row_wrap ? r_row :
                      (row_inc >= {1'b0, h_eff}) ? '0 : RW'(row_inc);

    // window taps: left column, centre column, right column from memory and input
    assign lt = GRAD_W'(r_win[0]);
    assign lm = GRAD_W'(r_win[1]);
    assign lb = GRAD_W'(r_win[2]);
    assign ct = GRAD_W'(r_win[3]);
    assign cb = GRAD_W'(r_win[5]);
    assign rt = GRAD_W'(r_rd_top);
    assign rm = GRAD_W'(r_rd_mid);
    assign rb = GRAD_W'(r_pixel);

    assign n_gx = (lt - rt) + ((lm - rm) <<< 1) + (lb - rb);
    assign n_gy = (lb + (cb <<< 1) + rb) - (lt + (ct <<< 1) + rt);

    // divide by four, rounding toward zero
    assign qx = QUOT_W'((r_gx + (r_gx[GRAD_W-1] ? GRAD_W'(3) : GRAD_W'(0))) >>> 2);
    assign qy = QUOT_W'((r_gy + (r_gy[GRAD_W-1] ? GRAD_W'(3) : GRAD_W'(0))) >>> 2);
    assign px2 = qx * qx;
    assign py2 = qy * qy;

    // one bit of the root per step; a sum of 65536 or more keeps every bit and saturates
    assign trial    = r_root | (t_pixel'(1) << i_cmd.root_bit);
    assign trial_sq = trial * trial;

    assign out_free = !r_out_valid || !i_stall;

    assign o_status.result_due = (r_row >= RW'(2)) && (r_col >= CW'(2));
    assign o_status.out_free   = out_free;

    // line stores: read on accept, write back when the window advances
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_rd_top <= line_store_two_above[r_col];
            r_rd_mid <= line_store_above[r_col];
            r_pixel  <= i_gray_pixel;
        end
        if (i_cmd.window) begin
            line_store_two_above[r_col] <= r_rd_mid;
            line_store_above[r_col]     <= r_pixel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width_cfg  <= WIDTH_CFG_W'(640);
            r_height_cfg <= HEIGHT_CFG_W'(480);
            r_col        <= '0;
            r_row        <= '0;
            for (int k = 0; k < WIN_TAPS; k++) begin
                r_win[k] <= '0;
            end
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_IMAGE_WIDTH:  r_width_cfg  <= i_cfg_data[WIDTH_CFG_W-1:0];
                CFG_IMAGE_HEIGHT: r_height_cfg <= i_cfg_data[HEIGHT_CFG_W-1:0];
                default: ;
            endcase
            // restart the frame
            r_col <= '0;
            r_row <= '0;
            for (int k = 0; k < WIN_TAPS; k++) begin
                r_win[k] <= '0;
            end
        end else if (i_cmd.window) begin
            r_win[0] <= r_win[3];
            r_win[1] <= r_win[4];
            r_win[2] <= r_win[5];
            r_win[3] <= r_rd_top;
            r_win[4] <= r_rd_mid;
            r_win[5] <= r_pixel;
            r_col    <= n_col;
            r_row    <= n_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.window) begin
            r_gx   <= n_gx;
            r_gy   <= n_gy;
            r_last <= (HW'(r_row) == h_eff - HW'(1)) && (WW'(r_col) == w_eff - WW'(1));
        end
        if (i_cmd.square) begin
            r_sq_x <= px2[SQ_W-1:0];
            r_sq_y <= py2[SQ_W-1:0];
        end
        if (i_cmd.sum) begin
            r_sum  <= SUM_W'(r_sq_x) + SUM_W'(r_sq_y);
            r_root <= '0;
        end else if (i_cmd.root_step) begin
            if (SUM_W'(trial_sq) <= r_sum) begin
                r_root <= trial;
            end
        end
        if (i_cmd.load_out) begin
            r_out_mag  <= r_root;
            r_out_last <= r_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_edge_magnitude = r_out_mag;
    assign o_frame_last     = r_out_last;

endmodule

`default_nettype wire

@@ src/sgm_control.sv @@
// Controller: sequences one pixel through read, window, square, sum, root and output.
`default_nettype none

module sgm_control
    import sgm_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_valid,
    output logic       o_stall,
    input  wire t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_WINDOW = 3'd1;
    localparam logic [2:0] S_SQUARE = 3'd2;
    localparam logic [2:0] S_SUM    = 3'd3;
    localparam logic [2:0] S_ROOT   = 3'd4;
    localparam logic [2:0] S_OUT    = 3'd5;

    logic [2:0]           r_state;
    logic [2:0]           n_state;
    logic [BIT_IDX_W-1:0] r_bit;
    logic [BIT_IDX_W-1:0] n_bit;

    assign o_stall = (r_state != S_IDLE) || !i_rst_n;

    always_comb begin
        n_state        = r_state;
        n_bit          = r_bit;
        o_cmd          = '0;
        o_cmd.root_bit = r_bit;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid && i_rst_n) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_WINDOW;
                end
            end
            S_WINDOW: begin
                o_cmd.window = 1'b1;
                n_state      = i_status.result_due ? S_SQUARE : S_IDLE;
            end
            S_SQUARE: begin
                o_cmd.square = 1'b1;
                n_state      = S_SUM;
            end
            S_SUM: begin
                o_cmd.sum = 1'b1;
                n_bit     = '1;
                n_state   = S_ROOT;
            end
            S_ROOT: begin
                o_cmd.root_step = 1'b1;
                n_bit           = r_bit - 1'b1;
                if (r_bit == '0) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                // hold the result until the output register is free
                if (i_status.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_bit   <= '0;
        end else begin
            r_state <= n_state;
            r_bit   <= n_bit;
        end
    end

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |-> i_status.out_free)
        else $error("result loaded while output register still full");

    a_accept_to_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.accept |=> (r_state == S_WINDOW))
        else $error("accepted pixel did not reach the window step");

    a_root_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROOT && r_bit == '0) |=> (r_state == S_OUT))
        else $error("root did not finish after the last bit");

    a_no_result_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WINDOW && !i_status.result_due) |=> (r_state == S_IDLE))
        else $error("border pixel did not return to idle");

endmodule

`default_nettype wire
